### rtl/rpwu_pkg.sv
package rpwu_pkg;

	localparam int unsigned IDX_W = 10;
	localparam int unsigned STEP_W = 31;
	localparam int unsigned FAC_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned PROD_W = STEP_W + FAC_W;
	localparam int unsigned FRAC_F = 14;

	// rounding constant for Q2.14 factors (half at bit 13)
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_F - 1);

	localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
	localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] W_MIN = 32'sh8000_0000;

	// stored gradient sign codes
	localparam logic [1:0] SIGN_ZERO = 2'd0;
	localparam logic [1:0] SIGN_PLUS = 2'd1;
	localparam logic [1:0] SIGN_MINUS = 2'd3;

	// request modes
	localparam logic MODE_INIT = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INC_FACTOR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEC_FACTOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_FREEZE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_BACKTRACK = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_OLD_VALUE = 3'd7;

	typedef struct packed {
		logic mode;
		logic [IDX_W-1:0] index;
		logic signed [31:0] gradient;
		logic signed [31:0] weight;
		logic error_rose;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		logic signed [31:0] new_weight;
		logic [STEP_W-1:0] new_step;
		logic backtracked;
	} out_item_t;

	typedef struct packed {
		logic [FAC_W-1:0] increase_factor;
		logic [FAC_W-1:0] decrease_factor;
		logic [STEP_W-1:0] max_step;
		logic [STEP_W-1:0] min_step;
		logic [STEP_W-1:0] init_step;
		logic use_freezing;
		logic use_backtracking;
		logic use_old_value;
	} cfg_t;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [1:0] sign;
		logic signed [31:0] change;
	} entry_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		entry_t data;
	} wr_t;

	typedef struct packed {
		logic s1_valid;
		logic [IDX_W-1:0] s1_index;
	} pipe_status_t;

endpackage

### rtl/rpwu_state_mem.sv
module rpwu_state_mem (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [rpwu_pkg::IDX_W-1:0] rd_idx,
	input rpwu_pkg::wr_t wr,
	output rpwu_pkg::entry_t rd_entry
);
	import rpwu_pkg::*;

	localparam int unsigned DEPTH = 1 << IDX_W;

	entry_t mem [DEPTH];
	entry_t rd_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic fwd_valid_q;
	logic [IDX_W-1:0] fwd_idx_q;
	entry_t fwd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
	end

	// registered read port, frozen while the pipeline holds
	always_ff @(posedge clk) begin
		if (en) begin
			rd_q <= mem[rd_idx];
			rd_idx_q <= rd_idx;
			fwd_idx_q <= wr.idx;
			fwd_data_q <= wr.data;
		end
	end

	// remember a write that landed on the same edge as the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (en) begin
			fwd_valid_q <= wr.en;
		end
	end

	// read returns old data on a collision, so forward the new entry
	assign rd_entry = (fwd_valid_q && fwd_idx_q == rd_idx_q) ? fwd_data_q : rd_q;

endmodule

### rtl/rpwu_pipe.sv
module rpwu_pipe (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic item_fire,
	input rpwu_pkg::in_item_t item,
	input rpwu_pkg::cfg_t cfg,
	input rpwu_pkg::entry_t rd_entry,
	output rpwu_pkg::wr_t wr,
	output rpwu_pkg::pipe_status_t status,
	output logic res_valid,
	output rpwu_pkg::out_item_t res
);
	import rpwu_pkg::*;

	// stage registers
	logic valid_s1, valid_s2, valid_s3;
	in_item_t item_s1;

	logic mode_s2;
	logic [IDX_W-1:0] idx_s2;
	logic pos_s2, neg_s2, grow_s2, shrink_s2, err_rose_s2;
	logic [STEP_W-1:0] step_s2;
	logic signed [31:0] change_s2;
	logic signed [31:0] weight_s2;
	logic [PROD_W-1:0] prod_s2;

	logic [IDX_W-1:0] idx_s3;
	logic [STEP_W-1:0] step_s3;
	logic signed [31:0] weight_s3;
	logic signed [31:0] operand_s3;
	logic bt_s3;

	// stage 1 signals
	logic pos1, neg1, old_pos1, old_neg1, grow1, shrink1;
	logic [FAC_W-1:0] factor1;
	logic [PROD_W-1:0] prod1;

	// stage 2 signals
	logic [PROD_W:0] rounded_full2;
	logic [PROD_W-FRAC_F:0] rounded2;
	logic [STEP_W-1:0] scaled2;
	logic [STEP_W-1:0] step_new2;
	logic [1:0] sign_new2;
	logic signed [31:0] move2;
	logic signed [31:0] change_new2;
	logic bt2;

	// stage 3 signals
	logic signed [32:0] sum3;
	logic signed [31:0] weight_out3;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_fire;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: sign compare and step scaling product
	always_comb begin
		pos1 = !item_s1.gradient[31] && (item_s1.gradient != 32'sd0);
		neg1 = item_s1.gradient[31];
		old_pos1 = (rd_entry.sign == SIGN_PLUS);
		old_neg1 = (rd_entry.sign == SIGN_MINUS);
		grow1 = (pos1 && old_pos1) || (neg1 && old_neg1);
		shrink1 = (pos1 && old_neg1) || (neg1 && old_pos1);
		factor1 = grow1 ? cfg.increase_factor : cfg.decrease_factor;
		prod1 = PROD_W'(rd_entry.step) * PROD_W'(factor1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (item_fire) begin
				item_s1 <= item;
			end
			mode_s2 <= item_s1.mode;
			idx_s2 <= item_s1.index;
			pos_s2 <= pos1;
			neg_s2 <= neg1;
			grow_s2 <= grow1;
			shrink_s2 <= shrink1;
			err_rose_s2 <= item_s1.error_rose;
			step_s2 <= rd_entry.step;
			change_s2 <= rd_entry.change;
			weight_s2 <= item_s1.weight;
			prod_s2 <= prod1;
		end
	end

	// stage 2: round, saturate and clamp the step, pick the change
	always_comb begin
		rounded_full2 = {1'b0, prod_s2} + {1'b0, ROUND_HALF};
		rounded2 = rounded_full2[PROD_W:FRAC_F];
		scaled2 = (|rounded2[PROD_W-FRAC_F:STEP_W]) ? STEP_MAX : rounded2[STEP_W-1:0];

		step_new2 = step_s2;
		if (mode_s2 == MODE_INIT) begin
			step_new2 = cfg.init_step;
		end else if (grow_s2) begin
			step_new2 = (scaled2 > cfg.max_step) ? cfg.max_step : scaled2;
		end else if (shrink_s2) begin
			step_new2 = (scaled2 < cfg.min_step) ? cfg.min_step : scaled2;
		end

		// move against the gradient sign
		priority if (pos_s2) begin
			move2 = -$signed({1'b0, step_new2});
		end else if (neg_s2) begin
			move2 = $signed({1'b0, step_new2});
		end else begin
			move2 = 32'sd0;
		end

		sign_new2 = pos_s2 ? SIGN_PLUS : (neg_s2 ? SIGN_MINUS : SIGN_ZERO);
		change_new2 = move2;
		bt2 = 1'b0;
		if (mode_s2 == MODE_INIT) begin
			sign_new2 = SIGN_ZERO;
			change_new2 = 32'sd0;
		end else if (shrink_s2) begin
			if (cfg.use_freezing) begin
				sign_new2 = SIGN_ZERO;
			end
			if (!cfg.use_backtracking) begin
				change_new2 = move2;
			end else if (!cfg.use_old_value || err_rose_s2) begin
				change_new2 = 32'sd0;
				bt2 = 1'b1;
			end else begin
				change_new2 = change_s2;
			end
		end
	end

	// write back at the end of stage 2
	always_comb begin
		wr.en = en && valid_s2;
		wr.idx = idx_s2;
		wr.data.step = step_new2;
		wr.data.sign = sign_new2;
		wr.data.change = change_new2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s3 <= idx_s2;
			step_s3 <= step_new2;
			weight_s3 <= weight_s2;
			operand_s3 <= bt2 ? change_s2 : change_new2;
			bt_s3 <= bt2;
		end
	end

	// stage 3: saturating weight add or backtrack
	always_comb begin
		if (bt_s3) begin
			sum3 = {weight_s3[31], weight_s3} - {operand_s3[31], operand_s3};
		end else begin
			sum3 = {weight_s3[31], weight_s3} + {operand_s3[31], operand_s3};
		end
		if (sum3[32] != sum3[31]) begin
			weight_out3 = sum3[32] ? W_MIN : W_MAX;
		end else begin
			weight_out3 = sum3[31:0];
		end
	end

	assign res_valid = valid_s3;
	assign res.out_index = idx_s3;
	assign res.new_weight = weight_out3;
	assign res.new_step = step_s3;
	assign res.backtracked = bt_s3;

	assign status.s1_valid = valid_s1;
	assign status.s1_index = item_s1.index;

endmodule

### rtl/rpwu_out_stage.sv
module rpwu_out_stage (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input rpwu_pkg::out_item_t res,
	output logic en,
	output logic result_valid,
	input logic result_stall,
	output rpwu_pkg::out_item_t result
);
	import rpwu_pkg::*;

	out_item_t out_q;
	out_item_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !result_stall;
	// the pipeline moves whenever the skid entry is empty
	assign en = !skid_valid_q;

	// occupancy of output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload moves
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

### rtl/rprop_weight_update.sv
// Rprop+ weight update, one parameter per request.
// Request channel: item_valid / item_stall / item. An item in init mode loads
// the entry at item.index with init_step, a zero sign and a zero last change
// and returns the weight unchanged; an update item adapts the step of that
// entry and moves, holds or backtracks the weight.
// Result channel: result_valid / result_stall / result, one result per item,
// in request order.
// The result passes through stage 1, stage 2, stage 3 and the output register.
// Throughput: one item per cycle while item_stall is low. An item whose index
// equals that of the item accepted just before it waits until that item has
// left the first stage, since the per-entry state is rewritten at the end of
// the second stage and the step product is formed in the first.
// State lives in a 1024 x 65 bit memory (step, sign, last change) whose read is
// registered on the accepting edge; a write on the read edge is forwarded.
// Reset clears the pipeline and loads the configuration defaults; the memory
// contents stay undefined until each entry is written in init mode.
// A stalled result is held in the output register while one more result
// goes into a skid entry; with the skid entry full, item_stall rises.
// The user writes configuration through cfg_we / cfg_index / cfg_data only while idle; the block does not enforce it.
module rprop_weight_update (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input rpwu_pkg::in_item_t item,
	output logic result_valid,
	input logic result_stall,
	output rpwu_pkg::out_item_t result,
	input logic cfg_we,
	input logic [rpwu_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rpwu_pkg::STEP_W-1:0] cfg_data
);
	import rpwu_pkg::*;

	cfg_t cfg_q;
	logic en;
	logic hazard;
	logic item_fire;
	entry_t rd_entry;
	wr_t wr;
	pipe_status_t status;
	logic res_valid;
	out_item_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.increase_factor <= 16'd19661;
			cfg_q.decrease_factor <= 16'd8192;
			cfg_q.max_step <= STEP_MAX;
			cfg_q.min_step <= '0;
			cfg_q.init_step <= 31'd655;
			cfg_q.use_freezing <= 1'b1;
			cfg_q.use_backtracking <= 1'b1;
			cfg_q.use_old_value <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INC_FACTOR: cfg_q.increase_factor <= cfg_data[FAC_W-1:0];
				CFG_DEC_FACTOR: cfg_q.decrease_factor <= cfg_data[FAC_W-1:0];
				CFG_MAX_STEP: cfg_q.max_step <= cfg_data;
				CFG_MIN_STEP: cfg_q.min_step <= cfg_data;
				CFG_INIT_STEP: cfg_q.init_step <= cfg_data;
				CFG_USE_FREEZE: cfg_q.use_freezing <= cfg_data[0];
				CFG_USE_BACKTRACK: cfg_q.use_backtracking <= cfg_data[0];
				CFG_USE_OLD_VALUE: cfg_q.use_old_value <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// same entry back to back: hold the newer request while the older one is in stage 1
	assign hazard = status.s1_valid && (status.s1_index == item.index);
	assign item_stall = !en || hazard;
	assign item_fire = item_valid && !item_stall;

	rpwu_state_mem u_mem (
		.clk (clk),
		.arst_n (arst_n),
		.en (en),
		.rd_idx (item.index),
		.wr (wr),
		.rd_entry (rd_entry)
	);

	rpwu_pipe u_pipe (
		.clk (clk),
		.arst_n (arst_n),
		.en (en),
		.item_fire (item_fire),
		.item (item),
		.cfg (cfg_q),
		.rd_entry (rd_entry),
		.wr (wr),
		.status (status),
		.res_valid (res_valid),
		.res (res)
	);

	rpwu_out_stage u_out (
		.clk (clk),
		.arst_n (arst_n),
		.res_valid (res_valid),
		.res (res),
		.en (en),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result (result)
	);

endmodule
